// ----- sv/rfa_pkg.sv -----
package rfa_pkg;

    localparam int OPERAND_BITS_DEF = 16;
    localparam int RES_NUM_W        = 32;
    localparam int RES_DEN_W        = 30;
    localparam int KIND_W           = 4;

    typedef enum logic [KIND_W-1:0] {
        OP_ADD    = 4'd0,
        OP_SUB    = 4'd1,
        OP_MUL    = 4'd2,
        OP_DIV    = 4'd3,
        OP_LT     = 4'd4,
        OP_LE     = 4'd5,
        OP_GT     = 4'd6,
        OP_GE     = 4'd7,
        OP_EQ     = 4'd8,
        OP_NE     = 4'd9,
        OP_REDUCE = 4'd10,
        OP_NEGATE = 4'd11
    } kind_t;

endpackage

// ----- sv/rfa_if.sv -----
interface rfa_in_if #(parameter int OPERAND_BITS = rfa_pkg::OPERAND_BITS_DEF);
    logic                      valid;
    logic                      ready;
    logic [rfa_pkg::KIND_W-1:0] kind;
    logic signed [OPERAND_BITS-1:0] a_num;
    logic [OPERAND_BITS-2:0]   a_den;
    logic signed [OPERAND_BITS-1:0] b_num;
    logic [OPERAND_BITS-2:0]   b_den;
    modport source (output valid, kind, a_num, a_den, b_num, b_den, input ready);
    modport sink   (input valid, kind, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rfa_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [rfa_pkg::RES_NUM_W-1:0] res_num;
    logic [rfa_pkg::RES_DEN_W-1:0]     res_den;
    logic                              cmp_true;
    logic                              div_zero;
    modport source (output valid, res_num, res_den, cmp_true, div_zero, input ready);
    modport sink   (input valid, res_num, res_den, cmp_true, div_zero, output ready);
endinterface

// ----- sv/rational_fraction_alu.sv -----
// Channel  Dir  Beat payload
// in       sink kind, a_num, a_den, b_num, b_den
// out      src  res_num, res_den, cmp_true, div_zero
//
// One beat in, one beat out. Busy from accept until the result is taken.
// W = 2*OPERAND_BITS+1 (33 by default). Compare, negate, unused opcodes
// and divide by zero register the result in S_PREP; other divides rerun
// S_PREP to reduce the cross products. Reducing paths run k Euclid
// remainder steps, each a load step plus a W-bit bit-serial restoring
// division, then two W-bit divisions scale n and d by the gcd. These
// divisions share one subtractor/shift unit; out ready low holds the
// result and the input. rst_n is async.
module rational_fraction_alu #(
    parameter int OPERAND_BITS = rfa_pkg::OPERAND_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    rfa_in_if.sink    in_ch,
    rfa_out_if.source out_ch
);
    localparam int W  = 2 * OPERAND_BITS + 1;   // magnitude width, covers cross sums
    localparam int SW = W + 1;                  // signed width
    localparam int CW = $clog2(W + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_PREP, S_GCD, S_DIVN, S_DIVD, S_DONE
    } state_t;

    state_t state_reg;
    logic signed [SW-1:0] lhs_reg, rhs_reg, n_reg, d_reg;
    logic [W-1:0] x_reg, y_reg, g_reg;
    // shared serial divider
    logic [W-1:0] dvd_reg, dvs_reg, quo_reg, rem_reg;
    logic [CW-1:0] cnt_reg;
    logic [rfa_pkg::KIND_W-1:0] kind_reg;
    logic neg_reg;
    logic signed [rfa_pkg::RES_NUM_W-1:0] onum_reg;
    logic [rfa_pkg::RES_DEN_W-1:0] oden_reg;
    logic ocmp_reg, odz_reg, ovalid_reg;

    logic signed [SW-1:0] an, bn, ad, bd, p_lhs, p_rhs, p_nn, p_dd;
    logic [W:0] rem_sh, rem_sub;
    logic [W-1:0] n_mag, d_mag;

    assign an = SW'(in_ch.a_num);
    assign bn = SW'(in_ch.b_num);
    assign ad = SW'($unsigned(in_ch.a_den));
    assign bd = SW'($unsigned(in_ch.b_den));
    assign p_lhs = an * bd;
    assign p_rhs = bn * ad;
    assign p_nn  = an * bn;
    assign p_dd  = ad * bd;

    assign rem_sh  = {rem_reg, dvd_reg[W-1]};
    assign rem_sub = rem_sh - {1'b0, dvs_reg};
    assign n_mag = n_reg[SW-1] ? W'(-n_reg) : W'(n_reg);
    assign d_mag = d_reg[SW-1] ? W'(-d_reg) : W'(d_reg);

    assign in_ch.ready     = (state_reg == S_IDLE);
    assign out_ch.valid    = ovalid_reg;
    assign out_ch.res_num  = onum_reg;
    assign out_ch.res_den  = oden_reg;
    assign out_ch.cmp_true = ocmp_reg;
    assign out_ch.div_zero = odz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            ovalid_reg <= 1'b0;
            lhs_reg    <= '0;
            rhs_reg    <= '0;
            n_reg      <= '0;
            d_reg      <= '0;
            x_reg      <= '0;
            y_reg      <= '0;
            g_reg      <= '0;
            dvd_reg    <= '0;
            dvs_reg    <= '0;
            quo_reg    <= '0;
            rem_reg    <= '0;
            cnt_reg    <= '0;
            kind_reg   <= '0;
            neg_reg    <= 1'b0;
            onum_reg   <= '0;
            oden_reg   <= '0;
            ocmp_reg   <= 1'b0;
            odz_reg    <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_ch.valid)
                    begin
                        kind_reg <= in_ch.kind;
                        lhs_reg  <= p_lhs;
                        rhs_reg  <= p_rhs;
                        // setup operands by opcode
                        case (in_ch.kind)
                            rfa_pkg::OP_ADD:
                            begin
                                n_reg <= (ad == bd) ? an + bn : p_lhs + p_rhs;
                                d_reg <= (ad == bd) ? ad : p_dd;
                            end
                            rfa_pkg::OP_SUB:
                            begin
                                n_reg <= (ad == bd) ? an - bn : p_lhs - p_rhs;
                                d_reg <= (ad == bd) ? ad : p_dd;
                            end
                            rfa_pkg::OP_MUL:
                            begin
                                n_reg <= p_nn;
                                d_reg <= p_dd;
                            end
                            default:
                            begin
                                n_reg <= an;
                                d_reg <= ad;
                            end
                        endcase
                        state_reg <= S_PREP;
                    end
                end
                S_PREP:
                begin
                    case (kind_reg) inside
                        rfa_pkg::OP_ADD, rfa_pkg::OP_SUB, rfa_pkg::OP_MUL,
                        rfa_pkg::OP_REDUCE:
                        begin
                            ocmp_reg <= 1'b0;
                            odz_reg  <= 1'b0;
                            x_reg <= n_mag;
                            y_reg <= d_mag;
                            neg_reg <= n_reg[SW-1] ^ d_reg[SW-1];
                            cnt_reg <= CW'(0);
                            state_reg <= S_GCD;
                        end
                        rfa_pkg::OP_DIV:
                        begin
                            n_reg <= lhs_reg;
                            d_reg <= rhs_reg;
                            if (rhs_reg == '0)
                            begin
                                onum_reg <= '0;
                                oden_reg <= rfa_pkg::RES_DEN_W'(1);
                                ocmp_reg <= 1'b0;
                                odz_reg  <= 1'b1;
                                ovalid_reg <= 1'b1;
                                state_reg <= S_DONE;
                            end
                            else
                            begin
                                // restart with cross products as n/d
                                kind_reg <= rfa_pkg::OP_REDUCE;
                            end
                        end
                        rfa_pkg::OP_NEGATE:
                        begin
                            onum_reg <= rfa_pkg::RES_NUM_W'(-n_reg);
                            oden_reg <= rfa_pkg::RES_DEN_W'(d_reg);
                            ocmp_reg <= 1'b0;
                            odz_reg  <= 1'b0;
                            ovalid_reg <= 1'b1;
                            state_reg <= S_DONE;
                        end
                        default:
                        begin
                            onum_reg <= '0;
                            oden_reg <= rfa_pkg::RES_DEN_W'(1);
                            odz_reg  <= 1'b0;
                            case (kind_reg)
                                rfa_pkg::OP_LT: ocmp_reg <= lhs_reg <  rhs_reg;
                                rfa_pkg::OP_LE: ocmp_reg <= lhs_reg <= rhs_reg;
                                rfa_pkg::OP_GT: ocmp_reg <= lhs_reg >  rhs_reg;
                                rfa_pkg::OP_GE: ocmp_reg <= lhs_reg >= rhs_reg;
                                rfa_pkg::OP_EQ: ocmp_reg <= lhs_reg == rhs_reg;
                                rfa_pkg::OP_NE: ocmp_reg <= lhs_reg != rhs_reg;
                                default:        ocmp_reg <= 1'b0;
                            endcase
                            ovalid_reg <= 1'b1;
                            state_reg <= S_DONE;
                        end
                    endcase
                end
                S_GCD:
                begin
                    // cnt 0: load x % y, or with y 0 take x as gcd; then step it
                    if (cnt_reg == CW'(0))
                    begin
                        if (y_reg == '0)
                        begin
                            g_reg   <= (x_reg == '0) ? W'(1) : x_reg;
                            dvd_reg <= n_mag;
                            dvs_reg <= (x_reg == '0) ? W'(1) : x_reg;
                            rem_reg <= '0;
                            cnt_reg <= CW'(W);
                            state_reg <= S_DIVN;
                        end
                        else
                        begin
                            dvd_reg <= x_reg;
                            dvs_reg <= y_reg;
                            rem_reg <= '0;
                            cnt_reg <= CW'(W);
                        end
                    end
                    else
                    begin
                        dvd_reg <= {dvd_reg[W-2:0], 1'b0};
                        rem_reg <= rem_sub[W] ? rem_sh[W-1:0] : rem_sub[W-1:0];
                        cnt_reg <= cnt_reg - CW'(1);
                        if (cnt_reg == CW'(1))
                        begin
                            x_reg <= y_reg;
                            y_reg <= rem_sub[W] ? rem_sh[W-1:0] : rem_sub[W-1:0];
                        end
                    end
                end
                S_DIVN, S_DIVD:
                begin
                    if (cnt_reg == CW'(1))
                    begin
                        rem_reg <= '0;
                        cnt_reg <= CW'(W);
                        if (state_reg == S_DIVN)
                        begin
                            n_reg   <= SW'({quo_reg[W-2:0], ~rem_sub[W]});
                            dvd_reg <= d_mag;
                            dvs_reg <= g_reg;
                            state_reg <= S_DIVD;
                        end
                        else
                        begin
                            onum_reg <= neg_reg ? -rfa_pkg::RES_NUM_W'(n_reg)
                                                : rfa_pkg::RES_NUM_W'(n_reg);
                            oden_reg <= rfa_pkg::RES_DEN_W'({quo_reg[W-2:0], ~rem_sub[W]});
                            ovalid_reg <= 1'b1;
                            state_reg <= S_DONE;
                        end
                    end
                    else
                    begin
                        dvd_reg <= {dvd_reg[W-2:0], 1'b0};
                        quo_reg <= {quo_reg[W-2:0], ~rem_sub[W]};
                        rem_reg <= rem_sub[W] ? rem_sh[W-1:0] : rem_sub[W-1:0];
                        cnt_reg <= cnt_reg - CW'(1);
                    end
                end
                S_DONE:
                begin
                    if (out_ch.ready)
                    begin
                        ovalid_reg <= 1'b0;
                        state_reg  <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // result only while done, busy means no accept
    a_valid_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> state_reg == S_DONE) else $error("valid outside done");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> !in_ch.ready) else $error("ready while result pending");
    a_den_nonzero_dz: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.div_zero) |-> out_ch.res_den == 1)
        else $error("div zero result not 0/1");

endmodule
